### hw/rtl/vpm_pkg.sv
// ----------------------------------------------------------------------------
// Voice pool manager package
// Request codes, status codes and the request and result records that travel
// down the chain of voice cells.
// ----------------------------------------------------------------------------
package vpm_pkg;

    localparam int FIELD_BITS   = 4;
    localparam int TOTAL_BITS   = 5;
    localparam int STATUS_BITS  = 2;
    // Only slots that fit the granted slot field can be handed out.
    localparam int ALLOC_REACH  = 16;

    localparam logic [FIELD_BITS-1:0] REQ_ALLOC   = 4'd0;
    localparam logic [FIELD_BITS-1:0] REQ_FREE    = 4'd1;
    localparam logic [FIELD_BITS-1:0] REQ_LOAD    = 4'd2;
    localparam logic [FIELD_BITS-1:0] REQ_ADVANCE = 4'd3;
    localparam logic [FIELD_BITS-1:0] REQ_STOP    = 4'd4;
    localparam logic [FIELD_BITS-1:0] REQ_PAUSE   = 4'd5;
    localparam logic [FIELD_BITS-1:0] REQ_RESUME  = 4'd6;
    localparam logic [FIELD_BITS-1:0] REQ_STATUS  = 4'd7;
    localparam logic [FIELD_BITS-1:0] REQ_COUNT   = 4'd8;

    localparam logic [STATUS_BITS-1:0] STATUS_STOPPED = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_PLAYING = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_PAUSED  = 2'd2;

    // Request fields that pass unchanged from cell to cell.
    typedef struct packed {
        logic [FIELD_BITS-1:0] req;
        logic [FIELD_BITS-1:0] slot;
        logic [FIELD_BITS-1:0] kind;
        logic [FIELD_BITS-1:0] chan;
        logic                  any;
        logic                  has;
    } t_token;

    // Result fields that the cells build up along the chain.
    typedef struct packed {
        logic                  granted;
        logic [FIELD_BITS-1:0] gslot;
        logic                  playing;
        logic                  paused;
        logic [TOTAL_BITS-1:0] total;
        logic                  ended;
    } t_acc;

endpackage

### hw/rtl/vpm_cell.sv
// ----------------------------------------------------------------------------
// Voice pool manager cell
// Holds the state of one voice, acts on the request passing through and hands
// the registered request and its partial result on to the next cell.
// ----------------------------------------------------------------------------
module vpm_cell #(
    parameter int IDX         = 0,
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  vpm_pkg::t_token        i_tok,
    input  logic [LENGTH_BITS-1:0] i_len,
    input  vpm_pkg::t_acc          i_acc,
    output logic                   o_valid,
    output vpm_pkg::t_token        o_tok,
    output logic [LENGTH_BITS-1:0] o_len,
    output vpm_pkg::t_acc          o_acc
);

    localparam logic [31:0] CELL_ID   = 32'(IDX);
    localparam bit          CAN_GRANT = (IDX < vpm_pkg::ALLOC_REACH);
    localparam logic [vpm_pkg::FIELD_BITS-1:0] GSLOT = vpm_pkg::FIELD_BITS'(IDX);

    logic                               r_active, n_active;
    logic                               r_paused, n_paused;
    logic                               r_has, n_has;
    logic [vpm_pkg::FIELD_BITS-1:0]     r_kind, n_kind;
    logic [vpm_pkg::FIELD_BITS-1:0]     r_chan, n_chan;
    logic [LENGTH_BITS-1:0]             r_pos, n_pos;
    logic [LENGTH_BITS-1:0]             r_len, n_len;

    logic                               r_valid;
    vpm_pkg::t_token                    r_tok;
    logic [LENGTH_BITS-1:0]             r_tlen;
    vpm_pkg::t_acc                      r_acc, n_acc;

    logic                               slot_hit;
    logic                               group_hit;
    logic [LENGTH_BITS-1:0]             pos_inc;

    assign slot_hit  = ({28'd0, i_tok.slot} == CELL_ID);
    assign group_hit = r_active && (r_kind == i_tok.kind)
                       && (i_tok.any || (r_chan == i_tok.chan));
    // The position saturates at its largest value.
    assign pos_inc   = (r_pos != '1) ? r_pos + 1'b1 : r_pos;

    always_comb begin
        n_active = r_active;
        n_paused = r_paused;
        n_has    = r_has;
        n_kind   = r_kind;
        n_chan   = r_chan;
        n_pos    = r_pos;
        n_len    = r_len;
        n_acc    = i_acc;
        if (i_valid) begin
            unique case (i_tok.req)
                vpm_pkg::REQ_ALLOC: begin
                    if (CAN_GRANT && !i_acc.granted && !r_active) begin
                        n_active      = 1'b1;
                        n_paused      = 1'b0;
                        n_has         = 1'b0;
                        n_pos         = '0;
                        n_len         = '0;
                        n_kind        = i_tok.kind;
                        n_chan        = i_tok.chan;
                        n_acc.granted = 1'b1;
                        n_acc.gslot   = GSLOT;
                    end
                end
                vpm_pkg::REQ_FREE: begin
                    if (slot_hit) begin
                        n_active = 1'b0;
                    end
                end
                vpm_pkg::REQ_LOAD: begin
                    if (slot_hit) begin
                        n_has = i_tok.has;
                        n_len = i_len;
                        n_pos = '0;
                    end
                end
                vpm_pkg::REQ_ADVANCE: begin
                    if (slot_hit && r_has) begin
                        n_pos = pos_inc;
                        if (pos_inc >= r_len) begin
                            n_acc.ended = r_active;
                            n_active    = 1'b0;
                        end
                    end
                end
                vpm_pkg::REQ_STOP: begin
                    if (group_hit) begin
                        n_active = 1'b0;
                    end
                end
                vpm_pkg::REQ_PAUSE: begin
                    if (group_hit) begin
                        n_paused = 1'b1;
                    end
                end
                vpm_pkg::REQ_RESUME: begin
                    if (group_hit) begin
                        n_paused = 1'b0;
                    end
                end
                vpm_pkg::REQ_STATUS: begin
                    if (group_hit) begin
                        n_acc.paused  = i_acc.paused | r_paused;
                        n_acc.playing = i_acc.playing | !r_paused;
                    end
                end
                vpm_pkg::REQ_COUNT: begin
                    n_acc.total = i_acc.total + {{(vpm_pkg::TOTAL_BITS-1){1'b0}}, r_active};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_paused <= 1'b0;
            r_has    <= 1'b0;
            r_kind   <= '0;
            r_chan   <= '0;
            r_pos    <= '0;
            r_len    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_paused <= n_paused;
            r_has    <= n_has;
            r_kind   <= n_kind;
            r_chan   <= n_chan;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_valid  <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok  <= i_tok;
        r_tlen <= i_len;
        r_acc  <= n_acc;
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_len   = r_tlen;
    assign o_acc   = r_acc;

endmodule

### hw/rtl/voice_pool_manager_core.sv
// ----------------------------------------------------------------------------
// Voice pool manager core
// A pool of voices, one cell per voice; each request walks the row of cells.
//
//   Channel   Handshake            Payload
//   request   i_valid / o_ready    i_req_type .. i_sample_length
//   result    o_valid / i_ready    o_granted .. o_voice_ended
//
// A request walks one cell per cycle and its result passes from the last cell
// into the output register; one request is in flight at a time, so a new request
// is taken only once the result of the last one has reached the output register.
// A finished result waits in the output register, with one spare holding
// register behind it, so a new request is taken while a result waits.
// Reset clears every voice at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module voice_pool_manager_core #(
    parameter int VOICES      = 16,
    parameter int LENGTH_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_req_type,
    input  logic [3:0]  i_slot,
    input  logic [3:0]  i_voice_kind,
    input  logic [3:0]  i_channel_number,
    input  logic        i_all_channels,
    input  logic        i_sample_present,
    input  logic [23:0] i_sample_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_granted,
    output logic [3:0]  o_granted_slot,
    output logic [1:0]  o_group_status,
    output logic [4:0]  o_active_total,
    output logic        o_voice_ended
);

    logic [VOICES:0]          w_valid;
    vpm_pkg::t_token          w_tok [0:VOICES];
    logic [LENGTH_BITS-1:0]   w_len [0:VOICES];
    vpm_pkg::t_acc            w_acc [0:VOICES];

    logic                     r_busy, n_busy;
    logic                     r_out_valid, n_out_valid;
    vpm_pkg::t_acc            r_out_acc, n_out_acc;
    logic                     r_hold_valid, n_hold_valid;
    vpm_pkg::t_acc            r_hold_acc, n_hold_acc;
    logic                     accept;
    logic                     take;
    logic                     exit_valid;

    assign o_ready    = !r_busy;
    assign accept     = i_valid && o_ready;
    assign take       = r_out_valid && i_ready;
    assign exit_valid = w_valid[VOICES];

    assign w_valid[0]     = accept;
    assign w_tok[0].req   = i_req_type;
    assign w_tok[0].slot  = i_slot;
    assign w_tok[0].kind  = i_voice_kind;
    assign w_tok[0].chan  = i_channel_number;
    assign w_tok[0].any   = i_all_channels;
    assign w_tok[0].has   = i_sample_present;
    assign w_len[0]       = LENGTH_BITS'(i_sample_length);
    assign w_acc[0]       = '0;

    for (genvar g = 0; g < VOICES; g++) begin : g_cell
        vpm_cell #(
            .IDX         (g),
            .LENGTH_BITS (LENGTH_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_tok   (w_tok[g]),
            .i_len   (w_len[g]),
            .i_acc   (w_acc[g]),
            .o_valid (w_valid[g+1]),
            .o_tok   (w_tok[g+1]),
            .o_len   (w_len[g+1]),
            .o_acc   (w_acc[g+1])
        );
    end

    always_comb begin
        n_busy       = r_busy;
        n_out_valid  = r_out_valid;
        n_out_acc    = r_out_acc;
        n_hold_valid = r_hold_valid;
        n_hold_acc   = r_hold_acc;
        if (take) begin
            n_out_valid = 1'b0;
        end
        priority if (exit_valid) begin
            if (!r_out_valid || take) begin
                n_out_valid = 1'b1;
                n_out_acc   = w_acc[VOICES];
                n_busy      = 1'b0;
            end else begin
                n_hold_valid = 1'b1;
                n_hold_acc   = w_acc[VOICES];
            end
        end else if (r_hold_valid && take) begin
            n_out_valid  = 1'b1;
            n_out_acc    = r_hold_acc;
            n_hold_valid = 1'b0;
            n_busy       = 1'b0;
        end else begin
        end
        if (accept) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_acc  <= n_out_acc;
        r_hold_acc <= n_hold_acc;
    end

    assign o_valid        = r_out_valid;
    assign o_granted      = r_out_acc.granted;
    assign o_granted_slot = r_out_acc.gslot;
    assign o_active_total = r_out_acc.total;
    assign o_voice_ended  = r_out_acc.ended;
    assign o_group_status = r_out_acc.playing ? vpm_pkg::STATUS_PLAYING :
                            r_out_acc.paused  ? vpm_pkg::STATUS_PAUSED  :
                                                vpm_pkg::STATUS_STOPPED;

`ifndef SYNTH
    // Only one request may be in the chain at any time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valid))
        else $error("more than one request in the cell chain");

    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exit_valid |-> r_busy)
        else $error("result left the chain with no request in flight");

    a_hold_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> (r_out_valid && r_busy))
        else $error("holding register filled ahead of the output register");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && w_valid[1]))
        else $error("accepted request did not enter the chain");
`endif

endmodule
